// ----- hw/rtl/ics_pkg.sv -----
// ----------------------------------------------------------------------------
// ics_pkg
// Shared constants, types and one's-complement helpers for the pseudo-header
// checksum block.
// ----------------------------------------------------------------------------
package ics_pkg;

    localparam int CHUNK_BYTES = 8;
    localparam int LENGTH_BITS = 16;
    localparam int DATA_W      = CHUNK_BYTES * 8;
    localparam int BC_W        = 4;
    localparam int LANE_IDX_W  = $clog2(CHUNK_BYTES);
    localparam int NUM_FIELDS  = 3;
    localparam int NUM_EXTRA   = NUM_FIELDS + 3;
    localparam int SUM_W       = 20;

    localparam logic REQ_ADDR    = 1'b0;
    localparam logic REQ_PAYLOAD = 1'b1;

    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

    localparam int OFF_ICMP = 2;
    localparam int OFF_UDP  = 6;
    localparam int OFF_TCP  = 16;

    localparam int SLOT_ICMP = 0;
    localparam int SLOT_UDP  = 1;
    localparam int SLOT_TCP  = 2;

    localparam int EXTRA_PROTO  = NUM_FIELDS;
    localparam int EXTRA_LEN_LO = NUM_FIELDS + 1;
    localparam int EXTRA_LEN_HI = NUM_FIELDS + 2;

    typedef logic [15:0]            word_t;
    typedef logic [LENGTH_BITS-1:0] len_t;
    typedef logic [SUM_W-1:0]       sum_t;

    localparam len_t  LEN_MAX   = '1;
    localparam word_t WORD_ONES = 16'hFFFF;

    typedef struct packed {
        logic                  sum_en;
        logic [NUM_FIELDS-1:0] cap;
        word_t                 part;
    } lane_res_t;

    typedef struct packed {
        logic                         last;
        logic [CHUNK_BYTES-1:0][15:0] words;
        logic [NUM_EXTRA-1:0][15:0]   extras;
    } beat_sums_t;

    typedef struct packed {
        logic  last;
        word_t word;
    } part_sum_t;

    // end-around carry fold of a wide sum down to 16 bits
    function automatic word_t oc_fold(input sum_t x);
        logic [16:0] t;
        logic [16:0] u;
        t = 17'(x[15:0]) + 17'(x[SUM_W-1:16]);
        u = 17'(t[15:0]) + 17'(t[16]);
        return u[15:0];
    endfunction

    function automatic word_t oc_add(input word_t a, input word_t b);
        return oc_fold(SUM_W'(a) + SUM_W'(b));
    endfunction

endpackage

// ----- hw/rtl/ics_req_if.sv -----
// ----------------------------------------------------------------------------
// ics_req_if
// Request channel: one pseudo-header or payload chunk per beat.
// ----------------------------------------------------------------------------
interface ics_req_if;
    import ics_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [DATA_W-1:0] data;
    logic [BC_W-1:0]   byte_count;
    logic              is_ipv6;
    logic [7:0]        proto;
    logic              last;

    modport source (
        output valid, req_type, data, byte_count, is_ipv6, proto, last,
        input  ready
    );

    modport sink (
        input  valid, req_type, data, byte_count, is_ipv6, proto, last,
        output ready
    );
endinterface

// ----- hw/rtl/ics_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ics_rsp_if
// Result channel: one checksum per packet.
// ----------------------------------------------------------------------------
interface ics_rsp_if;
    import ics_pkg::*;

    logic  valid;
    logic  ready;
    word_t checksum_value;

    modport source (
        output valid, checksum_value,
        input  ready
    );

    modport sink (
        input  valid, checksum_value,
        output ready
    );
endinterface

// ----- hw/rtl/internet_checksum_pseudo_header_top.sv -----
// ----------------------------------------------------------------------------
// internet_checksum_pseudo_header_top
// Internet checksum over pseudo-header and payload chunks, eight byte lanes
// per beat, merged by an adder tree into a running one's-complement sum.
// result path: the last beat passes the beat register, the merge sum and part registers, then the result register
// throughput: one beat per cycle unless a stalled result holds back the 16-bit accumulator
// a stalled result holds input only once the next last beat reaches the accumulator
// reset clears byte counter, held field words, accumulator and all valids
// ----------------------------------------------------------------------------
module internet_checksum_pseudo_header_top (
    input  logic      clk,
    input  logic      rst_n,
    ics_req_if.sink   req,
    ics_rsp_if.source rsp
);
    import ics_pkg::*;

    lane_res_t            lane_res [CHUNK_BYTES];
    len_t                 cnt_reg;
    len_t                 cnt_next;
    word_t                cap_reg  [NUM_FIELDS];
    word_t                cap_next [NUM_FIELDS];
    logic [BC_W-1:0]      n_bytes;
    logic [LENGTH_BITS:0] cnt_sum;
    logic [NUM_FIELDS-1:0] excl;
    logic [31:0]          len_wide;
    beat_sums_t           a_beat_reg;
    beat_sums_t           a_beat_next;
    logic                 a_valid_reg;
    logic                 a_ready;
    logic                 req_fire;
    logic                 c_valid;
    part_sum_t            c_part;
    logic                 c_ready;

    for (genvar i = 0; i < CHUNK_BYTES; i++)
    begin : g_lane
        ics_lane u_lane (
            .req_type   (req.req_type),
            .byte_val   (req.data[DATA_W-1-8*i -: 8]),
            .lane_idx   (LANE_IDX_W'(i)),
            .byte_count (req.byte_count),
            .base       (cnt_reg),
            .res        (lane_res[i])
        );
    end

    assign req.ready = !a_valid_reg || a_ready;
    assign req_fire  = req.valid && req.ready;

    always_comb
    begin
        n_bytes = (req.byte_count > BC_W'(CHUNK_BYTES)) ? BC_W'(CHUNK_BYTES) : req.byte_count;
        cnt_sum = {1'b0, cnt_reg} + (LENGTH_BITS + 1)'(n_bytes);
        if (req.req_type == REQ_PAYLOAD)
        begin
            cnt_next = cnt_sum[LENGTH_BITS] ? LEN_MAX : cnt_sum[LENGTH_BITS-1:0];
        end
        else
        begin
            cnt_next = cnt_reg;
        end

        for (int k = 0; k < NUM_FIELDS; k++)
        begin
            cap_next[k] = cap_reg[k];
            for (int i = 0; i < CHUNK_BYTES; i++)
            begin
                if (lane_res[i].cap[k])
                begin
                    cap_next[k] = cap_next[k] | lane_res[i].part;
                end
            end
        end

        excl = '0;
        if (req.proto == PROTO_ICMP || (req.proto == PROTO_ICMPV6 && req.is_ipv6))
        begin
            excl[SLOT_ICMP] = 1'b1;
        end
        else if (req.proto == PROTO_UDP)
        begin
            excl[SLOT_UDP] = 1'b1;
        end
        else if (req.proto == PROTO_TCP)
        begin
            excl[SLOT_TCP] = 1'b1;
        end

        len_wide = 32'(cnt_next);

        a_beat_next.last = req.last;
        for (int i = 0; i < CHUNK_BYTES; i++)
        begin
            a_beat_next.words[i] = lane_res[i].sum_en ? lane_res[i].part : '0;
        end
        a_beat_next.extras = '0;
        if (req.last)
        begin
            for (int k = 0; k < NUM_FIELDS; k++)
            begin
                a_beat_next.extras[k] = excl[k] ? '0 : cap_next[k];
            end
            a_beat_next.extras[EXTRA_PROTO]  = {8'h00, req.proto};
            a_beat_next.extras[EXTRA_LEN_LO] = len_wide[15:0];
            a_beat_next.extras[EXTRA_LEN_HI] = len_wide[31:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            a_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_FIELDS; k++)
            begin
                cap_reg[k] <= '0;
            end
        end
        else
        begin
            if (req.ready)
            begin
                a_valid_reg <= req.valid;
            end
            if (req_fire)
            begin
                // packet state clears once its last beat is in
                cnt_reg <= req.last ? '0 : cnt_next;
                for (int k = 0; k < NUM_FIELDS; k++)
                begin
                    cap_reg[k] <= req.last ? '0 : cap_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            a_beat_reg <= a_beat_next;
        end
    end

    ics_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .a_valid (a_valid_reg),
        .a_beat  (a_beat_reg),
        .a_ready (a_ready),
        .c_valid (c_valid),
        .c_part  (c_part),
        .c_ready (c_ready)
    );

    ics_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .c_valid (c_valid),
        .c_part  (c_part),
        .c_ready (c_ready),
        .rsp     (rsp)
    );
endmodule

// ----- hw/rtl/ics_lane.sv -----
// ----------------------------------------------------------------------------
// ics_lane
// One byte lane: finds the byte's payload offset, its half of the 16-bit
// word and whether it lands in a held checksum-field slot.
// ----------------------------------------------------------------------------
module ics_lane (
    input  logic                           req_type,
    input  logic [7:0]                     byte_val,
    input  logic [ics_pkg::LANE_IDX_W-1:0] lane_idx,
    input  logic [ics_pkg::BC_W-1:0]       byte_count,
    input  ics_pkg::len_t                  base,
    output ics_pkg::lane_res_t             res
);
    import ics_pkg::*;

    logic               is_payload;
    logic [LENGTH_BITS:0] off_sum;
    len_t               off;
    logic               odd;
    logic               lane_valid;
    logic [NUM_FIELDS-1:0] cap;

    always_comb
    begin
        is_payload = (req_type == REQ_PAYLOAD);
        off_sum    = {1'b0, base} + (LENGTH_BITS + 1)'(lane_idx);
        off        = off_sum[LENGTH_BITS] ? LEN_MAX : off_sum[LENGTH_BITS-1:0];
        odd        = is_payload ? off[0] : lane_idx[0];
        lane_valid = !is_payload || (BC_W'(lane_idx) < byte_count);

        cap            = '0;
        cap[SLOT_ICMP] = (off[LENGTH_BITS-1:1] == (LENGTH_BITS - 1)'(OFF_ICMP / 2));
        cap[SLOT_UDP]  = (off[LENGTH_BITS-1:1] == (LENGTH_BITS - 1)'(OFF_UDP / 2));
        cap[SLOT_TCP]  = (off[LENGTH_BITS-1:1] == (LENGTH_BITS - 1)'(OFF_TCP / 2));
        if (!(is_payload && lane_valid))
        begin
            cap = '0;
        end

        res.part   = odd ? {8'h00, byte_val} : {byte_val, 8'h00};
        res.cap    = cap;
        res.sum_en = lane_valid && (cap == '0);
    end
endmodule

// ----- hw/rtl/ics_merge.sv -----
// ----------------------------------------------------------------------------
// ics_merge
// Adder tree over the lane words and the end-of-packet terms, folded to a
// single 16-bit one's-complement word per beat.
// ----------------------------------------------------------------------------
module ics_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                a_valid,
    input  ics_pkg::beat_sums_t a_beat,
    output logic                a_ready,
    output logic                c_valid,
    output ics_pkg::part_sum_t  c_part,
    input  logic                c_ready
);
    import ics_pkg::*;

    logic      b_valid_reg;
    logic      b_last_reg;
    sum_t      b_lane_sum_reg;
    sum_t      b_extra_sum_reg;
    sum_t      lane_sum_next;
    sum_t      extra_sum_next;
    logic      b_ready;
    logic      c_take;
    logic      c_valid_reg;
    part_sum_t c_part_reg;
    part_sum_t c_part_next;

    always_comb
    begin
        lane_sum_next  = '0;
        extra_sum_next = '0;
        for (int i = 0; i < CHUNK_BYTES; i++)
        begin
            lane_sum_next = lane_sum_next + SUM_W'(a_beat.words[i]);
        end
        for (int k = 0; k < NUM_EXTRA; k++)
        begin
            extra_sum_next = extra_sum_next + SUM_W'(a_beat.extras[k]);
        end
    end

    always_comb
    begin
        c_part_next.last = b_last_reg;
        c_part_next.word = oc_add(oc_fold(b_lane_sum_reg), oc_fold(b_extra_sum_reg));
    end

    assign c_take  = !c_valid_reg || c_ready;
    assign b_ready = !b_valid_reg || c_take;
    assign a_ready = b_ready;
    assign c_valid = c_valid_reg;
    assign c_part  = c_part_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_ready)
            begin
                b_valid_reg <= a_valid;
            end
            if (c_take)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid)
        begin
            b_last_reg      <= a_beat.last;
            b_lane_sum_reg  <= lane_sum_next;
            b_extra_sum_reg <= extra_sum_next;
        end
        if (c_take && b_valid_reg)
        begin
            c_part_reg <= c_part_next;
        end
    end
endmodule

// ----- hw/rtl/ics_accum.sv -----
// ----------------------------------------------------------------------------
// ics_accum
// Running one's-complement accumulator and result register; inverts the sum
// on the last beat of a packet and clears for the next one.
// ----------------------------------------------------------------------------
module ics_accum (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               c_valid,
    input  ics_pkg::part_sum_t c_part,
    output logic               c_ready,
    ics_rsp_if.source          rsp
);
    import ics_pkg::*;

    word_t acc_reg;
    word_t acc_next;
    logic  out_valid_reg;
    word_t out_sum_reg;
    logic  out_free;
    logic  consume;

    assign out_free = !out_valid_reg || rsp.ready;
    assign consume  = c_valid && (!c_part.last || out_free);
    assign c_ready  = !c_valid || consume;
    assign acc_next = oc_add(acc_reg, c_part.word);

    assign rsp.valid          = out_valid_reg;
    assign rsp.checksum_value = out_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (consume && c_part.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (consume)
            begin
                acc_reg <= c_part.last ? '0 : acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && c_part.last)
        begin
            out_sum_reg <= acc_next ^ WORD_ONES;
        end
    end
endmodule

// ----- hw/rtl/ics_checker.sv -----
// ----------------------------------------------------------------------------
// ics_checker
// Port-level checks on the checksum block: result handshake and result count
// against last beats accepted.
// ----------------------------------------------------------------------------
module ics_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  logic          req_last,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  ics_pkg::word_t rsp_checksum_value
);
    import ics_pkg::*;

    localparam logic [2:0] MAX_PENDING = 3'd4;

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       last_fire;
    logic       rsp_fire;

    assign last_fire = req_valid && req_ready && req_last;
    assign rsp_fire  = rsp_valid && rsp_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (last_fire && !rsp_fire)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (!last_fire && rsp_fire)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // stalled result keeps valid
    a_rsp_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result valid dropped while stalled");

    // stalled result keeps its value
    a_rsp_hold_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_checksum_value))
        else $error("result value changed while stalled");

    // a result only for a packet whose last beat went in
    a_rsp_has_packet: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 3'd0)
        else $error("result without a pending packet");

    // at most one packet per pipeline slot in flight
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= MAX_PENDING)
        else $error("too many packets in flight");

    // no result in the first cycle out of reset
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !rsp_valid)
        else $error("result valid right after reset");
endmodule

bind internet_checksum_pseudo_header_top ics_checker u_ics_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .req_last           (req.last),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_checksum_value (rsp.checksum_value)
);

// ----- dv/tb_internet_checksum_pseudo_header_top.sv -----
// ----------------------------------------------------------------------------
// tb_internet_checksum_pseudo_header_top
// Self-checking bench for the pseudo-header checksum block. A tracker class
// folds every accepted request beat into its own one's-complement sum, byte
// counter and held field words, and queues the expected checksum on each last
// beat. Returned checksums are compared in order. Stimulus is a directed set
// (protocol exclusions, short and odd payloads, zero and oversized byte
// counts, last on an address chunk), then random packets with noise.
// The sender runs in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module tb_internet_checksum_pseudo_header_top;
    import ics_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_BEATS = 950;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 12;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    localparam int NO_SLOT = -1;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    class checksum_tracker;
        word_t acc;
        len_t  seen;
        word_t held [NUM_FIELDS];
        word_t expected_sums [$];
        int    errors;
        int    checked;

        function new();
            clear_packet();
            errors  = 0;
            checked = 0;
        endfunction

        function void clear_packet();
            acc  = '0;
            seen = '0;
            foreach (held[k])
                held[k] = '0;
        endfunction

        function word_t ones_add(word_t a, word_t b);
            logic [16:0] t;
            t = {1'b0, a} + {1'b0, b};
            return t[15:0] + {15'd0, t[16]};
        endfunction

        function void take_payload_byte(logic [7:0] b);
            word_t part;
            part = seen[0] ? {8'h00, b} : {b, 8'h00};
            if (seen == len_t'(OFF_ICMP) || seen == len_t'(OFF_ICMP + 1))
                held[SLOT_ICMP] |= part;
            else if (seen == len_t'(OFF_UDP) || seen == len_t'(OFF_UDP + 1))
                held[SLOT_UDP] |= part;
            else if (seen == len_t'(OFF_TCP) || seen == len_t'(OFF_TCP + 1))
                held[SLOT_TCP] |= part;
            else
                acc = ones_add(acc, part);
            if (seen != LEN_MAX)
                seen++;
        endfunction

        function void note_beat(logic rtype, logic [63:0] data, logic [3:0] bc,
                                logic v6, logic [7:0] pr, logic lst);
            int    n;
            int    excl;
            word_t s;
            logic [7:0] b;
            if (rtype == REQ_ADDR) begin
                for (int i = 0; i < CHUNK_BYTES; i++) begin
                    b   = data[63 - 8 * i -: 8];
                    acc = ones_add(acc, (i % 2 == 1) ? {8'h00, b} : {b, 8'h00});
                end
            end
            else begin
                n = (bc > CHUNK_BYTES) ? CHUNK_BYTES : int'(bc);
                for (int i = 0; i < n; i++)
                    take_payload_byte(data[63 - 8 * i -: 8]);
            end
            if (!lst)
                return;
            if (pr == PROTO_ICMP || (pr == PROTO_ICMPV6 && v6))
                excl = SLOT_ICMP;
            else if (pr == PROTO_UDP)
                excl = SLOT_UDP;
            else if (pr == PROTO_TCP)
                excl = SLOT_TCP;
            else
                excl = NO_SLOT;
            s = acc;
            for (int i = 0; i < NUM_FIELDS; i++)
                if (i != excl)
                    s = ones_add(s, held[i]);
            s = ones_add(s, {8'h00, pr});
            s = ones_add(s, seen[15:0]);
            expected_sums.push_back(~s);
            clear_packet();
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_sum(word_t got);
            word_t want;
            if (expected_sums.size() == 0)
                report($sformatf("checksum %h with no packet pending", got));
            else
            begin
                want = expected_sums.pop_front();
                checked++;
                if (got !== want)
                    report($sformatf("checksum_value got %h expected %h", got, want));
            end
        endtask

        task final_check();
            if (expected_sums.size() != 0)
                report($sformatf("%0d checksums never returned", expected_sums.size()));
        endtask
    endclass

    logic clk;
    logic rst_n;

    ics_req_if req_ch();
    ics_rsp_if rsp_ch();

    internet_checksum_pseudo_header_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    checksum_tracker tracker = new();

    int       beats_sent   = 0;
    int       packets_sent = 0;
    int       burst_left   = 0;
    int       idle_cycles  = 0;
    rx_mode_t rx_mode      = RX_OPEN;
    logic [7:0] rx_cnt     = '0;

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // result sink stall pattern
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            rx_cnt <= rx_cnt + 8'd1;
            if (rx_cnt[5:0] == 6'd0)
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
            case (rx_mode)
                RX_OPEN:   rsp_ch.ready <= 1'b1;
                RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default:   rsp_ch.ready <= (rx_cnt[3:0] < 4'd10);
            endcase
        end
    end

    // beat and result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                tracker.note_beat(req_ch.req_type, req_ch.data, req_ch.byte_count,
                                  req_ch.is_ipv6, req_ch.proto, req_ch.last);
            if (rsp_ch.valid && rsp_ch.ready)
                tracker.check_sum(rsp_ch.checksum_value);
        end
    end

    // watchdog
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [63:0] pick_data(int fill);
        if (fill == FILL_ZERO)
            return '0;
        if (fill == FILL_ONES || $urandom_range(0, 7) == 0)
            return '1;
        return {$urandom, $urandom};
    endfunction

    task automatic send_beat(logic rtype, logic [63:0] data, logic [3:0] bc,
                             logic v6, logic [7:0] pr, logic lst);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= rtype;
        req_ch.data       <= data;
        req_ch.byte_count <= bc;
        req_ch.is_ipv6    <= v6;
        req_ch.proto      <= pr;
        req_ch.last       <= lst;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        beats_sent++;
    endtask

    // address chunks then payload; with no payload the last address chunk ends it
    task automatic send_packet(logic v6, logic [7:0] pr, int n_addr, int n_bytes, int fill);
        int left;
        int bc;
        for (int i = 0; i < n_addr; i++)
            send_beat(REQ_ADDR, pick_data(fill), 4'($urandom_range(0, 15)), v6, pr,
                      n_bytes == 0 && i == n_addr - 1);
        left = n_bytes;
        while (left > 0)
        begin
            bc   = (left > CHUNK_BYTES) ? CHUNK_BYTES : left;
            left = left - bc;
            send_beat(REQ_PAYLOAD, pick_data(fill), 4'(bc), v6, pr, left == 0);
        end
        packets_sent++;
    endtask

    task automatic send_noise_packet();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            send_beat(1'($urandom_range(0, 1)), pick_data(FILL_RANDOM),
                      4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)), i == n - 1);
        packets_sent++;
    endtask

    function automatic logic [7:0] pick_proto();
        case ($urandom_range(0, 5))
            0:       return PROTO_ICMP;
            1:       return PROTO_TCP;
            2:       return PROTO_UDP;
            3:       return PROTO_ICMPV6;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        int  rand_start;
        int  len;
        logic v6;
        rst_n             = 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_ADDR;
        req_ch.data       <= '0;
        req_ch.byte_count <= '0;
        req_ch.is_ipv6    <= 1'b0;
        req_ch.proto      <= '0;
        req_ch.last       <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cases
        send_packet(1'b0, PROTO_TCP, 1, 20, FILL_ONES);
        send_packet(1'b0, PROTO_UDP, 1, 8, FILL_ZERO);
        send_packet(1'b0, PROTO_ICMP, 1, 12, FILL_RANDOM);
        send_packet(1'b1, PROTO_ICMPV6, 2, 8, FILL_ONES);
        send_packet(1'b0, PROTO_ICMPV6, 1, 8, FILL_ONES);
        send_packet(1'b1, 8'hFF, 1, 3, FILL_RANDOM);
        send_packet(1'b0, PROTO_TCP, 1, 10, FILL_RANDOM);
        send_packet(1'b1, 8'h00, 1, 0, FILL_ONES);
        // zero byte count payload only
        send_beat(REQ_PAYLOAD, '1, 4'd0, 1'b0, PROTO_UDP, 1'b1);
        // byte counts above a chunk
        send_beat(REQ_PAYLOAD, pick_data(FILL_RANDOM), 4'd15, 1'b1, PROTO_TCP, 1'b0);
        send_beat(REQ_PAYLOAD, pick_data(FILL_RANDOM), 4'd9, 1'b1, PROTO_TCP, 1'b1);
        // short chunk ahead of the last one shifts word alignment
        send_beat(REQ_PAYLOAD, pick_data(FILL_RANDOM), 4'd3, 1'b0, PROTO_TCP, 1'b0);
        send_beat(REQ_PAYLOAD, pick_data(FILL_RANDOM), 4'd8, 1'b0, PROTO_TCP, 1'b0);
        send_beat(REQ_PAYLOAD, pick_data(FILL_RANDOM), 4'd8, 1'b0, PROTO_TCP, 1'b1);
        packets_sent += 3;

        // random packets, mostly well formed
        rand_start = beats_sent;
        while (beats_sent - rand_start < RANDOM_BEATS)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                v6  = 1'($urandom_range(0, 1));
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200)
                                                  : $urandom_range(0, 40);
                send_packet(v6, pick_proto(), v6 ? 4 : 1, len, FILL_RANDOM);
            end
            else
                send_noise_packet();
        end
        req_ch.valid <= 1'b0;

        while (tracker.expected_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        tracker.final_check();

        $display("sent %0d packets in %0d beats, directed corner cases then random traffic",
                 packets_sent, beats_sent);
        $display("compared %0d checksums, %0d mismatches", tracker.checked, tracker.errors);
        if (tracker.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
